>>> sv/ilwe_pkg.sv
// shared widths, codes and defaults for the indexed list with erase
`default_nettype none

package ilwe_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 4;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_ERASE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_UNDER = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

endpackage

`default_nettype wire

>>> sv/ilwe_req_if.sv
// request channel: action, value and index words
`default_nettype none

interface ilwe_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          action;
    logic signed [ilwe_pkg::DATA_W-1:0]  value;
    logic [ilwe_pkg::IDX_W-1:0]          index;

    modport source (output valid, output action, output value, output index, input ready);
    modport sink   (input valid, input action, input value, input index, output ready);
endinterface

`default_nettype wire

>>> sv/ilwe_rsp_if.sv
// result channel: read value, count, empty flag and status
`default_nettype none

interface ilwe_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ilwe_pkg::DATA_W-1:0]   read_value;
    logic [ilwe_pkg::CNT_OUT_W-1:0]       count;
    logic                                 empty_res;
    logic [1:0]                           status;

    modport source (output valid, output read_value, output count, output empty_res,
                    output status, input ready);
    modport sink   (input valid, input read_value, input count, input empty_res,
                    input status, output ready);
endinterface

`default_nettype wire

>>> sv/indexed_list_with_erase.sv
// indexed list with erase: top level, store plus request sequencer
// push, pop and out-of-range requests load the result register from the idle state;
// a read passes through S_RDATA; an erase at index i moves the entries above i down
// one slot in S_ERASE over separate memory ports (one read and one write per cycle)
// a new word is taken once the previous one is done and the result register is free
// reset clears the count and the control; the entry memory is not cleared
`default_nettype none

module indexed_list_with_erase #(
    parameter int DEPTH = ilwe_pkg::DEPTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ilwe_req_if.sink   req,
    ilwe_rsp_if.source rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [ilwe_pkg::DATA_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic [ilwe_pkg::DATA_W-1:0] mem_rdata;

    ilwe_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ilwe_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

>>> sv/ilwe_mem.sv
// entry store: one write port, one read port with registered read data
`default_nettype none

module ilwe_mem #(
    parameter int DEPTH = ilwe_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [ilwe_pkg::DATA_W-1:0] wdata,
    input  wire logic                        re,
    input  wire logic [AW-1:0]               raddr,
    output      logic [ilwe_pkg::DATA_W-1:0] rdata
);

    logic [ilwe_pkg::DATA_W-1:0] mem_array [DEPTH];
    logic [ilwe_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/ilwe_ctrl.sv
// request sequencer: count, erase compaction walk and result register
`default_nettype none

module ilwe_ctrl #(
    parameter int DEPTH = ilwe_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    ilwe_req_if.sink                         req,
    ilwe_rsp_if.source                       rsp,
    output      logic                        mem_we,
    output      logic [AW-1:0]               mem_waddr,
    output      logic [ilwe_pkg::DATA_W-1:0] mem_wdata,
    output      logic                        mem_re,
    output      logic [AW-1:0]               mem_raddr,
    input  wire logic [ilwe_pkg::DATA_W-1:0] mem_rdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > ilwe_pkg::IDX_W) ? CNT_W : ilwe_pkg::IDX_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RDATA = 3'b010,
        S_ERASE = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            ptr_reg, ptr_next;
    logic                        out_valid_reg, out_valid_next;
    logic [ilwe_pkg::DATA_W-1:0] rv_reg, rv_next;
    ilwe_pkg::status_t           status_reg, status_next;

    logic             accept;
    logic             in_range;
    logic [CNT_W-1:0] idx_p1;
    logic [CNT_W-1:0] ptr_p1;

    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign in_range  = CMP_W'(req.index) < CMP_W'(count_reg);
    // only used when index is below count, so it fits
    assign idx_p1    = CNT_W'(CMP_W'(req.index)) + 1'b1;
    assign ptr_p1    = ptr_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        rv_next        = rv_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_waddr      = AW'(count_reg);
        mem_wdata      = req.value;
        mem_re         = 1'b0;
        mem_raddr      = AW'(req.index);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (ilwe_pkg::action_t'(req.action))
                        ilwe_pkg::ACT_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            rv_next        = '0;
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_next = ilwe_pkg::STAT_FULL;
                            end
                            else
                            begin
                                status_next = ilwe_pkg::STAT_OK;
                                mem_we      = 1'b1;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        ilwe_pkg::ACT_POP:
                        begin
                            out_valid_next = 1'b1;
                            rv_next        = '0;
                            if (count_reg == '0)
                            begin
                                status_next = ilwe_pkg::STAT_UNDER;
                            end
                            else
                            begin
                                status_next = ilwe_pkg::STAT_OK;
                                count_next  = count_reg - 1'b1;
                            end
                        end
                        ilwe_pkg::ACT_READ:
                        begin
                            if (!in_range)
                            begin
                                out_valid_next = 1'b1;
                                rv_next        = '0;
                                status_next    = ilwe_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_RDATA;
                            end
                        end
                        ilwe_pkg::ACT_ERASE:
                        begin
                            if (!in_range)
                            begin
                                out_valid_next = 1'b1;
                                rv_next        = '0;
                                status_next    = ilwe_pkg::STAT_RANGE;
                            end
                            else if (idx_p1 < count_reg)
                            begin
                                // start the walk: fetch the word above the gap
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(idx_p1);
                                ptr_next   = idx_p1;
                                state_next = S_ERASE;
                            end
                            else
                            begin
                                // last entry erased, nothing to move
                                out_valid_next = 1'b1;
                                rv_next        = '0;
                                status_next    = ilwe_pkg::STAT_OK;
                                count_next     = count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RDATA:
            begin
                out_valid_next = 1'b1;
                rv_next        = mem_rdata;
                status_next    = ilwe_pkg::STAT_OK;
                state_next     = S_IDLE;
            end
            S_ERASE:
            begin
                // write lags read by one slot, so the two never meet
                mem_we    = 1'b1;
                mem_waddr = AW'(ptr_reg - 1'b1);
                mem_wdata = mem_rdata;
                if (ptr_p1 < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(ptr_p1);
                    ptr_next  = ptr_p1;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    rv_next        = '0;
                    status_next    = ilwe_pkg::STAT_OK;
                    count_next     = count_reg - 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        rv_reg     <= rv_next;
        status_reg <= status_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = rv_reg;
    assign rsp.count      = ilwe_pkg::CNT_OUT_W'(count_reg);
    assign rsp.empty_res  = (count_reg == '0);
    assign rsp.status     = status_reg;

endmodule

`default_nettype wire

>>> sv/ilwe_checker.sv
// port-level checks for the indexed list with erase, bound to the top level
`default_nettype none

module ilwe_checker #(
    parameter int DEPTH = ilwe_pkg::DEPTH_DEF
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [ilwe_pkg::DATA_W-1:0]    read_value,
    input wire logic [ilwe_pkg::CNT_OUT_W-1:0] count,
    input wire logic                           empty_res,
    input wire logic [1:0]                     status
);

    // a held result keeps its word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(count)
            && $stable(status))
    else $error("result word changed while stalled");

    // no new request while an untaken result sits in the output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || out_ready)
    else $error("request taken over a pending result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ilwe_pkg::STAT_UNDER |-> count == '0 && empty_res)
    else $error("underflow reported on a non-empty list");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ilwe_pkg::STAT_FULL
            |-> count == ilwe_pkg::CNT_OUT_W'(DEPTH) && !empty_res)
    else $error("full reported below capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ilwe_pkg::STAT_OK |-> read_value == '0)
    else $error("nonzero read value on a failed request");

endmodule

bind indexed_list_with_erase ilwe_checker #(
    .DEPTH (DEPTH)
) u_ilwe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .read_value (rsp.read_value),
    .count      (rsp.count),
    .empty_res  (rsp.empty_res),
    .status     (rsp.status)
);

`default_nettype wire
